// ===== rtl/aes_dec_pkg.sv =====
// AES decrypt package: S-box tables, GF(2^8) helpers and constants.
// No dependencies.
package aes_dec_pkg;

  localparam int unsigned KeyStoreDepth = 60;
  localparam int unsigned KeyAddrW      = 6;
  localparam int unsigned CfgIdxW       = 3;

  localparam logic [CfgIdxW-1:0] RegKeySize = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKey0    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKey1    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKey2    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegKey3    = 3'd4;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] x;
    r = '0;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ x;
      x = xtime(x);
    end
    gf_mul = r;
  endfunction

  function automatic logic [7:0] gf_inv(input logic [7:0] x);
    logic [7:0] r;
    r = '0;
    for (int i = 1; i < 256; i++) begin
      if (gf_mul(x, 8'(i)) == 8'h01) r = 8'(i);
    end
    gf_inv = r;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
    rotl8 = (x << n) | (x >> (8 - n));
  endfunction

  function automatic logic [7:0] sbox_calc(input logic [7:0] x);
    logic [7:0] s;
    s = gf_inv(x);
    sbox_calc = s ^ rotl8(s, 1) ^ rotl8(s, 2) ^ rotl8(s, 3) ^ rotl8(s, 4) ^ 8'h63;
  endfunction

  function automatic logic [255:0][7:0] gen_sbox();
    logic [255:0][7:0] t;
    for (int i = 0; i < 256; i++) t[i] = sbox_calc(8'(i));
    gen_sbox = t;
  endfunction

  function automatic logic [255:0][7:0] gen_inv_sbox();
    logic [255:0][7:0] t;
    logic [7:0] x;
    for (int i = 0; i < 256; i++) begin
      x = 8'(i);
      t[i] = gf_inv(rotl8(x, 1) ^ rotl8(x, 3) ^ rotl8(x, 6) ^ 8'h05);
    end
    gen_inv_sbox = t;
  endfunction

  localparam logic [255:0][7:0] Sbox    = gen_sbox();
  localparam logic [255:0][7:0] InvSbox = gen_inv_sbox();

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {Sbox[w[31:24]], Sbox[w[23:16]], Sbox[w[15:8]], Sbox[w[7:0]]};
  endfunction

  function automatic logic [7:0] mul9(input logic [7:0] a);
    logic [7:0] a2, a4, a8;
    a2 = xtime(a); a4 = xtime(a2); a8 = xtime(a4);
    mul9 = a8 ^ a;
  endfunction
  function automatic logic [7:0] mul11(input logic [7:0] a);
    logic [7:0] a2, a4, a8;
    a2 = xtime(a); a4 = xtime(a2); a8 = xtime(a4);
    mul11 = a8 ^ a2 ^ a;
  endfunction
  function automatic logic [7:0] mul13(input logic [7:0] a);
    logic [7:0] a2, a4, a8;
    a2 = xtime(a); a4 = xtime(a2); a8 = xtime(a4);
    mul13 = a8 ^ a4 ^ a;
  endfunction
  function automatic logic [7:0] mul14(input logic [7:0] a);
    logic [7:0] a2, a4, a8;
    a2 = xtime(a); a4 = xtime(a2); a8 = xtime(a4);
    mul14 = a8 ^ a4 ^ a2;
  endfunction

  // state byte order: byte k = column k/4, row k%4, byte 0 in bits 127:120
  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [127:0] t;
    int d;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        d = ((c + r) % 4) * 4 + r;
        t[127 - 8*d -: 8] = InvSbox[s[127 - 8*(c*4+r) -: 8]];
      end
    end
    inv_shift_sub = t;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32*c -: 8];
      a1 = s[119 - 32*c -: 8];
      a2 = s[111 - 32*c -: 8];
      a3 = s[103 - 32*c -: 8];
      t[127 - 32*c -: 8] = mul14(a0) ^ mul11(a1) ^ mul13(a2) ^ mul9(a3);
      t[119 - 32*c -: 8] = mul9(a0) ^ mul14(a1) ^ mul11(a2) ^ mul13(a3);
      t[111 - 32*c -: 8] = mul13(a0) ^ mul9(a1) ^ mul14(a2) ^ mul11(a3);
      t[103 - 32*c -: 8] = mul11(a0) ^ mul13(a1) ^ mul9(a2) ^ mul14(a3);
    end
    inv_mix = t;
  endfunction

endpackage

// ===== rtl/aes_block_decrypt.sv =====
// AES inverse cipher top level: key expansion into a round key memory and
// an iterative round engine. Depends on aes_dec_pkg.
//
//  channel   handshake                 payload
//  -------   ------------------------  -------------------------------
//  cfg       cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
//  cmd       start / busy              cipher_high_i, cipher_low_i
//  result    done_o strobe             plain_high_o, plain_low_o
//
// A block runs Nr+1 rounds; each round takes a read setup state, then reads one
// key word per cycle on the single read port. The first block after reset or a key
// or key size write first expands the key: an initial word is written directly,
// a derived word is read, then written. Config is taken only while idle and
// start is low. Reset clears the control, key and state registers but not the
// round key memory. Results cannot be stalled.
module aes_block_decrypt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [aes_dec_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]                     cfg_data_i,
  input  logic                            start,
  output logic                            busy,
  input  logic [63:0]                     cipher_high_i,
  input  logic [63:0]                     cipher_low_i,
  output logic                            done_o,
  output logic [63:0]                     plain_high_o,
  output logic [63:0]                     plain_low_o
);
  import aes_dec_pkg::*;

  localparam int unsigned AW = KeyAddrW;

  typedef enum logic [2:0] {
    StIdle, StExpRd, StExpWr, StRdKey, StRound
  } state_e;

  state_e      state_q;
  logic [1:0]  mode_q;
  logic [3:0][63:0] key_q;
  logic        ready_q;
  logic [AW-1:0] idx_q;      // expansion word index
  logic [AW-1:0] tot_q;
  logic [3:0]  nk_cnt_q;     // i mod nk
  logic [7:0]  rcon_q;
  logic [31:0] prev_q;
  logic [3:0]  round_q;
  logic [1:0]  col_q;
  logic [127:0] st_q;
  logic [95:0] rk_q;
  logic [63:0] pin_hi_q, pin_lo_q;
  logic        done_q;
  logic [127:0] out_q;

  logic [31:0] mem [KeyStoreDepth];
  logic [31:0] rd_q;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] wdata;

  logic [3:0] nk;
  logic [3:0] nr;
  always_comb begin
    unique case (mode_q)
      2'd0:    nk = 4'd4;
      2'd1:    nk = 4'd6;
      default: nk = 4'd8;
    endcase
    nr = nk + 4'd6;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  // expansion word compute; prev_q is word i-1, rd_q is word i-nk
  logic [31:0] t_word, kinit;
  logic        is_init;
  always_comb begin
    is_init = {2'b0, idx_q} < {2'b0, AW'(nk)};
    kinit = idx_q[0] ? key_q[idx_q[2:1]][31:0] : key_q[idx_q[2:1]][63:32];
    t_word = prev_q;
    if (nk_cnt_q == 4'd0)
      t_word = sub_word({prev_q[23:0], prev_q[31:24]}) ^ {rcon_q, 24'h0};
    else if (nk == 4'd8 && nk_cnt_q == 4'd4)
      t_word = sub_word(prev_q);
  end

  logic [AW-1:0] rk_addr;
  assign rk_addr = AW'({round_q, col_q});

  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = kinit;
    raddr = rk_addr;
    if (state_q == StExpRd) begin
      raddr = idx_q - AW'(nk);
    end else if (state_q == StExpWr) begin
      we    = 1'b1;
      wdata = is_init ? kinit : (rd_q ^ t_word);
    end
  end

  logic [127:0] rk_full, after_ark, round_out;
  always_comb begin
    rk_full = {rk_q, rd_q};
    after_ark = st_q ^ rk_full;
    if (round_q == nr) round_out = inv_shift_sub(after_ark);
    else if (round_q == 4'd0) round_out = after_ark;
    else round_out = inv_shift_sub(inv_mix(after_ark));
  end

  assign cfg_ready_o  = (state_q == StIdle) && !start;
  assign busy         = (state_q != StIdle);
  assign done_o       = done_q;
  assign plain_high_o = out_q[127:64];
  assign plain_low_o  = out_q[63:0];

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start) begin
      pin_hi_q <= cipher_high_i;
      pin_lo_q <= cipher_low_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      mode_q   <= '0;
      key_q    <= '0;
      ready_q  <= 1'b0;
      idx_q    <= '0;
      tot_q    <= '0;
      nk_cnt_q <= '0;
      rcon_q   <= 8'h01;
      prev_q   <= '0;
      round_q  <= '0;
      col_q    <= '0;
      st_q     <= '0;
      rk_q     <= '0;
      done_q   <= 1'b0;
      out_q    <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start) begin
            st_q    <= {cipher_high_i, cipher_low_i};
            round_q <= nr;
            col_q   <= '0;
            if (ready_q) begin
              state_q <= StRdKey;
            end else begin
              idx_q    <= '0;
              tot_q    <= AW'({nk + 4'd7, 2'b00});
              nk_cnt_q <= '0;
              rcon_q   <= 8'h01;
              state_q  <= StExpWr;
            end
          end else if (cfg_valid_i) begin
            unique case (cfg_index_i)
              RegKeySize: mode_q   <= cfg_data_i[1:0];
              RegKey0:    key_q[0] <= cfg_data_i;
              RegKey1:    key_q[1] <= cfg_data_i;
              RegKey2:    key_q[2] <= cfg_data_i;
              RegKey3:    key_q[3] <= cfg_data_i;
              default: ;
            endcase
            if (cfg_index_i <= RegKey3) ready_q <= 1'b0;
          end
        end
        StExpRd: state_q <= StExpWr;
        StExpWr: begin
          prev_q <= wdata;
          if (!is_init) begin
            if (nk_cnt_q == 4'd0) rcon_q <= xtime(rcon_q);
          end
          nk_cnt_q <= (nk_cnt_q == nk - 4'd1) ? 4'd0 : nk_cnt_q + 4'd1;
          if (idx_q == tot_q - AW'(1)) begin
            ready_q <= 1'b1;
            st_q    <= {pin_hi_q, pin_lo_q};
            state_q <= StRdKey;
          end else begin
            idx_q   <= idx_q + AW'(1);
            state_q <= (idx_q + AW'(1) >= AW'(nk)) ? StExpRd : StExpWr;
          end
        end
        StRdKey: begin
          col_q   <= col_q + 2'd1;
          state_q <= StRound;
        end
        StRound: begin
          rk_q <= {rk_q[63:0], rd_q};
          if (col_q == 2'd0) begin
            st_q <= round_out;
            if (round_q == 4'd0) begin
              out_q   <= round_out;
              done_q  <= 1'b1;
              state_q <= StIdle;
            end else begin
              round_q <= round_q - 4'd1;
              state_q <= StRdKey;
            end
          end else begin
            col_q <= col_q + 2'd1;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ===== rtl/aes_dec_checker.sv =====
// Port-level checker for aes_block_decrypt, bound to the top level.
// Depends only on the top level's port names.
module aes_dec_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic cfg_valid_i,
  input logic cfg_ready_o,
  input logic start,
  input logic busy,
  input logic done_o
);

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("done without busy");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("start not taken");
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> (!busy && !start)) else $error("cfg ready while busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("done while busy");
endmodule

bind aes_block_decrypt aes_dec_checker u_chk (
  .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .start, .busy, .done_o
);

// ===== sim/tb_top.sv =====
// Self-checking testbench for aes_block_decrypt: directed table plus random blocks,
// with a built-in AES inverse cipher predictor. Depends on aes_dec_pkg and the DUT.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import aes_dec_pkg::*;

  localparam logic [CfgIdxW-1:0] RegSpare0 = 3'd5;
  localparam logic [CfgIdxW-1:0] RegSpare1 = 3'd7;

  localparam logic [63:0] VecK0 = 64'h0001020304050607;
  localparam logic [63:0] VecK1 = 64'h08090a0b0c0d0e0f;
  localparam logic [63:0] VecK2 = 64'h1011121314151617;
  localparam logic [63:0] VecK3 = 64'h18191a1b1c1d1e1f;
  localparam logic [63:0] VecPh = 64'h0011223344556677;
  localparam logic [63:0] VecPl = 64'h8899aabbccddeeff;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } blk_t;

  typedef struct {
    logic [63:0] ch;
    logic [63:0] cl;
    bit          known;
    logic [63:0] ph;
    logic [63:0] pl;
  } vec_t;

  typedef struct {
    bit          rekey;
    bit          junk_wr;
    logic [1:0]  mode;
    logic [63:0] k0, k1, k2, k3;
    vec_t        v;
  } row_t;

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [63:0] cfg_data_i;
  logic start, busy, done_o;
  logic [63:0] cipher_high_i, cipher_low_i, plain_high_o, plain_low_o;

  aes_block_decrypt i_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .start, .busy, .cipher_high_i, .cipher_low_i,
    .done_o, .plain_high_o, .plain_low_o
  );

  logic [1:0]  key_mode;
  logic [63:0] key_w [4];
  logic [31:0] rk [60];
  bit          rk_valid;
  logic [7:0]  sb [256];
  logic [7:0]  isb [256];
  blk_t        plain_q [$];
  int          errors;
  bit          no_idle;

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return r;
  endfunction

  function automatic logic [7:0] ginv(logic [7:0] x);
    logic [7:0] r, b;
    int e;
    r = 8'h01; b = x; e = 254;
    while (e != 0) begin
      if (e & 1) r = gmul(r, b);
      b = gmul(b, b);
      e >>= 1;
    end
    return r;
  endfunction

  function automatic logic [7:0] rl(logic [7:0] x, int n);
    return (x << n) | (x >> (8 - n));
  endfunction

  function automatic int key_words_n();
    return key_mode == 0 ? 4 : (key_mode == 1 ? 6 : 8);
  endfunction

  task automatic build_sboxes();
    logic [7:0] s, x;
    for (int i = 0; i < 256; i++) begin
      x = i[7:0];
      s = ginv(x);
      sb[i] = s ^ rl(s, 1) ^ rl(s, 2) ^ rl(s, 3) ^ rl(s, 4) ^ 8'h63;
      isb[i] = ginv(rl(x, 1) ^ rl(x, 3) ^ rl(x, 6) ^ 8'h05);
    end
  endtask

  function automatic logic [31:0] subw(logic [31:0] w);
    return {sb[w[31:24]], sb[w[23:16]], sb[w[15:8]], sb[w[7:0]]};
  endfunction

  task automatic expand_schedule();
    int nk;
    logic [31:0] t;
    logic [7:0] rc;
    nk = key_words_n();
    rc = 8'h01;
    for (int i = 0; i < nk; i++)
      rk[i] = (i & 1) ? key_w[i >> 1][31:0] : key_w[i >> 1][63:32];
    for (int i = nk; i < 4 * (nk + 7); i++) begin
      t = rk[i-1];
      if (i % nk == 0) begin
        t = subw({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gmul(rc, 8'h02);
      end else if (nk == 8 && i % nk == 4) begin
        t = subw(t);
      end
      rk[i] = rk[i-nk] ^ t;
    end
    rk_valid = 1;
  endtask

  function automatic logic [7:0] sbyte(logic [127:0] s, int k);
    return s[127 - 8*k -: 8];
  endfunction

  function automatic logic [127:0] add_rk(logic [127:0] s, int rnd);
    for (int c = 0; c < 4; c++) s[127 - 32*c -: 32] ^= rk[rnd*4 + c];
    return s;
  endfunction

  function automatic logic [127:0] unshift_sub(logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127 - 8*(((c + r) % 4)*4 + r) -: 8] = isb[sbyte(s, c*4 + r)];
    return t;
  endfunction

  function automatic logic [127:0] unmix(logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = sbyte(s, 4*c); a1 = sbyte(s, 4*c+1); a2 = sbyte(s, 4*c+2); a3 = sbyte(s, 4*c+3);
      t[127-32*c -: 8] = gmul(a0,14) ^ gmul(a1,11) ^ gmul(a2,13) ^ gmul(a3,9);
      t[119-32*c -: 8] = gmul(a0,9) ^ gmul(a1,14) ^ gmul(a2,11) ^ gmul(a3,13);
      t[111-32*c -: 8] = gmul(a0,13) ^ gmul(a1,9) ^ gmul(a2,14) ^ gmul(a3,11);
      t[103-32*c -: 8] = gmul(a0,11) ^ gmul(a1,13) ^ gmul(a2,9) ^ gmul(a3,14);
    end
    return t;
  endfunction

  task automatic decrypt_block(input logic [63:0] ch, input logic [63:0] cl,
                               output blk_t pt);
    logic [127:0] s;
    int nr;
    if (!rk_valid) expand_schedule();
    nr = key_words_n() + 6;
    s = add_rk({ch, cl}, nr);
    for (int r = nr - 1; r > 0; r--) s = unmix(add_rk(unshift_sub(s), r));
    s = add_rk(unshift_sub(s), 0);
    pt = s;
  endtask

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic idle_burst();
    if (!no_idle && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    idle_burst();
    cfg_valid_i <= 1; cfg_index_i <= idx; cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    case (idx)
      RegKeySize: key_mode = val[1:0] == 2'd3 ? 2'd2 : val[1:0];
      RegKey0:    key_w[0] = val;
      RegKey1:    key_w[1] = val;
      RegKey2:    key_w[2] = val;
      RegKey3:    key_w[3] = val;
      default: ;
    endcase
    if (idx <= RegKey3) rk_valid = 0;
    @(posedge clk_i);
  endtask

  task automatic send_block(input vec_t v);
    blk_t pt;
    idle_burst();
    start <= 1; cipher_high_i <= v.ch; cipher_low_i <= v.cl;
    do @(posedge clk_i); while (busy);
    start <= 0;
    decrypt_block(v.ch, v.cl, pt);
    if (v.known && (pt.hi != v.ph || pt.lo != v.pl)) begin
      $display("%0t predictor vs table: exp %h%h got %h%h", $time, v.ph, v.pl, pt.hi, pt.lo);
      errors++;
    end
    plain_q.push_back(v.known ? blk_t'({v.ph, v.pl}) : pt);
    @(posedge clk_i);
  endtask

  task automatic drain();
    int n;
    n = 0;
    while (plain_q.size() != 0 && n < 5000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (80) @(posedge clk_i);
  endtask

  task automatic load_key(input logic [1:0] m, input logic [63:0] k0, k1, k2, k3);
    write_reg(RegKeySize, 64'(m));
    write_reg(RegKey0, k0);
    write_reg(RegKey1, k1);
    write_reg(RegKey2, k2);
    write_reg(RegKey3, k3);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (plain_q.size() == 0) begin
        $display("%0t unexpected result %h%h", $time, plain_high_o, plain_low_o);
        errors++;
      end else begin
        if (plain_high_o !== plain_q[0].hi) begin
          $display("%0t plain_high exp %h got %h", $time, plain_q[0].hi, plain_high_o);
          errors++;
        end
        if (plain_low_o !== plain_q[0].lo) begin
          $display("%0t plain_low exp %h got %h", $time, plain_q[0].lo, plain_low_o);
          errors++;
        end
        void'(plain_q.pop_front());
      end
    end
  end

  function automatic logic [63:0] r64();
    return {$urandom, $urandom};
  endfunction

  initial begin
    row_t dir [12];
    vec_t v;
    int n;
    build_sboxes();
    errors = 0; no_idle = 0;
    key_mode = 0; rk_valid = 0;
    foreach (key_w[i]) key_w[i] = 0;
    rst_ni = 0; cfg_valid_i = 0; cfg_index_i = 0; cfg_data_i = 0;
    start = 0; cipher_high_i = 0; cipher_low_i = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // FIPS-197 appendix C vectors, then extremes and ignored register writes
    dir = '{
      '{1, 0, 2'd0, VecK0, VecK1, 64'h0, 64'h0,
        '{64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1, VecPh, VecPl}},
      '{0, 0, 2'd0, 0, 0, 0, 0, '{64'h0, 64'h0, 0, 0, 0}},
      '{0, 0, 2'd0, 0, 0, 0, 0, '{'1, '1, 0, 0, 0}},
      '{0, 0, 2'd0, 0, 0, 0, 0, '{64'h8000000000000000, 64'h1, 0, 0, 0}},
      '{1, 0, 2'd1, VecK0, VecK1, VecK2, '1,
        '{64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191, 1, VecPh, VecPl}},
      '{0, 0, 2'd0, 0, 0, 0, 0, '{'1, 64'h0, 0, 0, 0}},
      '{1, 0, 2'd2, VecK0, VecK1, VecK2, VecK3,
        '{64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1, VecPh, VecPl}},
      '{0, 0, 2'd0, 0, 0, 0, 0, '{64'h0, '1, 0, 0, 0}},
      '{1, 0, 2'd3, '1, '1, '1, '1,
        '{64'h0123456789abcdef, 64'hfedcba9876543210, 0, 0, 0}},
      '{0, 0, 2'd0, 0, 0, 0, 0, '{'1, '1, 0, 0, 0}},
      '{1, 0, 2'd0, 64'h0, 64'h0, 64'h0, 64'h0, '{64'h0, 64'h0, 0, 0, 0}},
      '{0, 1, 2'd0, 0, 0, 0, 0, '{64'h55aa55aa55aa55aa, 64'haa55aa55aa55aa55, 0, 0, 0}}
    };
    foreach (dir[i]) begin
      if (dir[i].rekey || dir[i].junk_wr) drain();
      if (dir[i].rekey)
        load_key(dir[i].mode, dir[i].k0, dir[i].k1, dir[i].k2, dir[i].k3);
      if (dir[i].junk_wr) begin
        write_reg(RegSpare1, r64());
        write_reg(RegSpare0, r64());
      end
      send_block(dir[i].v);
    end
    drain();

    for (int ph = 0; ph < 24; ph++) begin
      load_key(2'($urandom_range(0, 3)), r64(), r64(), r64(), r64());
      if (ph % 5 == 2) write_reg(RegKey0, r64());
      if (ph >= 20) no_idle = 1;
      n = 60;
      for (int i = 0; i < n; i++) begin
        v = '{r64(), r64(), 0, 0, 0};
        send_block(v);
      end
      drain();
    end

    if (plain_q.size() != 0) begin
      $display("%0t %0d results never arrived", $time, plain_q.size());
      errors++;
    end
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
